@@ sv/tile_background_pixel_fetch_macros.svh @@
// ----------------------------------------------------------------------------
// Tile background pixel fetch assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TILE_BACKGROUND_PIXEL_FETCH_MACROS_SVH
`define TILE_BACKGROUND_PIXEL_FETCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBPF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tbpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Tile background pixel fetch package
// Register indexes, request kinds, layer control bits and the gray table.
// ----------------------------------------------------------------------------
package tbpf_pkg;

  localparam int VRAM_BYTES = 8192;
  localparam int VRAM_AW    = 13;
  localparam int BANK_AW    = VRAM_AW - 1;
  localparam int BANK_DEPTH = VRAM_BYTES / 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int LC_W       = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // Tile maps live above 0x1800; the two top address bits are then set.
  localparam logic [1:0] MAP_REGION = 2'b11;

  localparam int LC_BG_ON    = 0;
  localparam int LC_WIN_ON   = 1;
  localparam int LC_WIN_MAP1 = 2;
  localparam int LC_BG_MAP1  = 3;
  localparam int LC_UNSIGNED = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCROLL_X   = 3'd0,
    CFG_SCROLL_Y   = 3'd1,
    CFG_WINDOW_X   = 3'd2,
    CFG_WINDOW_Y   = 3'd3,
    CFG_BG_PALETTE = 3'd4,
    CFG_LAYER_CTRL = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_RENDER = 1'b1
  } action_e;

  function automatic logic [7:0] gray_of(input logic [1:0] shade);
    logic [7:0] g;
    case (shade)
      2'd0:    g = 8'd255;
      2'd1:    g = 8'd170;
      2'd2:    g = 8'd85;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

@@ sv/tile_background_pixel_fetch.sv @@
// ----------------------------------------------------------------------------
// Tile background pixel fetch
// Video RAM with background and window tile lookup, palette and gray output.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless the output stalls, either a video
// RAM byte write (tuser 0) or a pixel render (tuser 1). A render goes through the
// map read, plane read and output registers. The video RAM is split into an even
// and an odd byte bank so that both plane bytes of a tile row come out of one read;
// the map read and the plane read are two pipelined reads of those banks; a stalled
// output holds the whole pipeline. Writes and renders off screen give no result.
`include "tile_background_pixel_fetch_macros.svh"

module tile_background_pixel_fetch #(
  parameter int SCREEN_WIDTH = 160
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tbpf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tbpf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // vram_addr[12:0], vram_data[20:13], pixel_x[28:21], pixel_y[36:29], zeros above
  input  logic [tbpf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action[0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // shade[1:0], gray[9:2], zeros above
  output logic [tbpf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // from_window[0]
  output logic                             m_axis_tuser
);
  import tbpf_pkg::*;

  logic [7:0]      scroll_x_q, scroll_y_q, window_x_q, window_y_q, palette_q;
  logic [LC_W-1:0] lctrl_q;

  logic              adv, accept, wr_en;
  logic [VRAM_AW-1:0] wr_addr;
  logic [7:0]        wr_data, px, py, bx, by;
  logic              onscreen, blank, in_win, map1;
  logic [VRAM_AW-1:0] map_addr;

  logic [7:0] bank_even [BANK_DEPTH];
  logic [7:0] bank_odd  [BANK_DEPTH];

  logic        st1_vld_q, st1_bank_q, st1_blank_q, st1_win_q;
  logic [2:0]  st1_bx_q, st1_by_q;
  logic [7:0]  map_even_q, map_odd_q;
  logic [7:0]  tile_no;
  logic [BANK_AW-1:0] row_waddr;

  logic        st2_vld_q, st2_blank_q, st2_win_q;
  logic [2:0]  st2_bx_q;
  logic [7:0]  pln_lo_q, pln_hi_q;
  logic [1:0]  code, shade;

  logic        m_vld_q, m_win_q;
  logic [1:0]  m_shade_q;
  logic [7:0]  m_gray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_x_q <= '0;
      scroll_y_q <= '0;
      window_x_q <= '0;
      window_y_q <= '0;
      palette_q  <= '0;
      lctrl_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCROLL_X:   scroll_x_q <= cfg_data_i;
        CFG_SCROLL_Y:   scroll_y_q <= cfg_data_i;
        CFG_WINDOW_X:   window_x_q <= cfg_data_i;
        CFG_WINDOW_Y:   window_y_q <= cfg_data_i;
        CFG_BG_PALETTE: palette_q  <= cfg_data_i;
        CFG_LAYER_CTRL: lctrl_q    <= cfg_data_i[LC_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv           = !m_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign wr_en         = accept && (action_e'(s_axis_tuser) == ACT_WRITE);
  assign wr_addr       = s_axis_tdata[12:0];
  assign wr_data       = s_axis_tdata[20:13];
  assign px            = s_axis_tdata[28:21];
  assign py            = s_axis_tdata[36:29];

  always_comb begin
    onscreen = {1'b0, px} < 9'(SCREEN_WIDTH);
    blank    = !lctrl_q[LC_BG_ON] && !lctrl_q[LC_WIN_ON];
    in_win   = lctrl_q[LC_WIN_ON] && (py >= window_y_q) && (px >= window_x_q);
    if (in_win) begin
      bx   = px - window_x_q;
      by   = py - window_y_q;
      map1 = lctrl_q[LC_WIN_MAP1];
    end else begin
      bx   = px + scroll_x_q;
      by   = py + scroll_y_q;
      map1 = lctrl_q[LC_BG_MAP1];
    end
    map_addr = {MAP_REGION, map1, by[7:3], bx[7:3]};
  end

  // Stage one: the map entry is read; its bank follows the low address bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_vld_q <= 1'b0;
    end else if (adv) begin
      st1_vld_q <= accept && (action_e'(s_axis_tuser) == ACT_RENDER) && onscreen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st1_bank_q  <= map_addr[0];
      st1_blank_q <= blank;
      st1_win_q   <= in_win;
      st1_bx_q    <= bx[2:0];
      st1_by_q    <= by[2:0];
    end
  end

  assign tile_no   = st1_bank_q ? map_odd_q : map_even_q;
  assign row_waddr = {!(lctrl_q[LC_UNSIGNED] || tile_no[7]), tile_no, st1_by_q};

  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_addr[0]) begin
      bank_even[wr_addr[VRAM_AW-1:1]] <= wr_data;
    end
    if (adv) begin
      map_even_q <= bank_even[map_addr[VRAM_AW-1:1]];
      pln_lo_q   <= bank_even[row_waddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_addr[0]) begin
      bank_odd[wr_addr[VRAM_AW-1:1]] <= wr_data;
    end
    if (adv) begin
      map_odd_q <= bank_odd[map_addr[VRAM_AW-1:1]];
      pln_hi_q  <= bank_odd[row_waddr];
    end
  end

  // Stage two: both plane bytes of the tile row are present.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st2_vld_q <= 1'b0;
    end else if (adv) begin
      st2_vld_q <= st1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st2_blank_q <= st1_blank_q;
      st2_win_q   <= st1_win_q;
      st2_bx_q    <= st1_bx_q;
    end
  end

  always_comb begin
    code  = {pln_hi_q[3'd7 - st2_bx_q], pln_lo_q[3'd7 - st2_bx_q]};
    shade = st2_blank_q ? 2'd0 : palette_q[{code, 1'b0} +: 2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= st2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_shade_q <= shade;
      m_gray_q  <= gray_of(shade);
      m_win_q   <= st2_win_q;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {6'd0, m_gray_q, m_shade_q};
  assign m_axis_tuser  = m_win_q;

  `TBPF_ASSERT_NEXT(a_write_no_result,
      accept && (action_e'(s_axis_tuser) == ACT_WRITE), !st1_vld_q,
      "A write request entered the render pipeline.")
  `TBPF_ASSERT_SAME(a_window_needs_enable, m_vld_q && m_win_q, lctrl_q[LC_WIN_ON],
      "A window pixel was shown while the window layer is off.")
  `TBPF_ASSERT_NEXT(a_stall_holds_planes, st2_vld_q && !adv,
      $stable(pln_lo_q) && $stable(pln_hi_q) && $stable(st2_bx_q),
      "Plane data changed while the pipeline was stalled.")
  `TBPF_ASSERT_SAME(a_blank_is_white, m_vld_q && !lctrl_q[LC_BG_ON] && !lctrl_q[LC_WIN_ON],
      m_shade_q == 2'd0 && !m_win_q,
      "A pixel with both layers off was not white.")

endmodule

@@ test/tile_background_pixel_fetch_test.sv @@
// ----------------------------------------------------------------------------
// Tile background pixel fetch testbench
// Fills video RAM and renders pixels through the stream ports under several
// layer, scroll, window and palette settings. Every expected pixel is worked
// out from a model of the video RAM when its request is taken and compared
// field by field with the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_background_pixel_fetch_test;
  import tbpf_pkg::*;

  localparam int SCREEN_W      = 160;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQS    = 175;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 600;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PRINT_LIMIT   = 200;

  localparam logic [12:0] MAP0_BASE   = 13'h1800;
  localparam logic [12:0] MAP1_BASE   = 13'h1C00;
  localparam logic [12:0] SIGNED_BASE = 13'h1000;

  localparam logic [LC_W-1:0] LC_BG     = LC_W'(1 << LC_BG_ON);
  localparam logic [LC_W-1:0] LC_WIN    = LC_W'(1 << LC_WIN_ON);
  localparam logic [LC_W-1:0] LC_WMAP1  = LC_W'(1 << LC_WIN_MAP1);
  localparam logic [LC_W-1:0] LC_BGMAP1 = LC_W'(1 << LC_BG_MAP1);
  localparam logic [LC_W-1:0] LC_UNS    = LC_W'(1 << LC_UNSIGNED);

  typedef struct packed {
    action_e    act;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [7:0]  px;
    logic [7:0]  py;
  } pixel_req_t;

  typedef struct packed {
    logic [1:0] shade;
    logic [7:0] gray;
    logic       from_window;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  tile_background_pixel_fetch #(
    .SCREEN_WIDTH(SCREEN_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  logic [7:0]  cfg_shadow [6];
  logic [7:0]  vram_model [VRAM_BYTES];
  logic [7:0]  planned_ram [VRAM_BYTES];
  logic        planned_set [VRAM_BYTES];
  pixel_req_t  pending_reqs [$];
  pixel_t      expected_pixels [$];
  pixel_req_t  cur_req;
  logic        steady = 1'b0;
  logic        out_hold = 1'b0;
  int          send_wait = 0;
  int          recv_wait = 0;
  int          requests_taken = 0;
  int          renders_taken = 0;
  int          writes_taken = 0;
  int          pixels_checked = 0;
  int          mismatches = 0;
  int          planned_count = 0;
  int          settings_applied = 0;
  int          cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < VRAM_BYTES; i++) begin
      planned_set[i] = 1'b0;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic void locate(input logic [7:0] px, input logic [7:0] py,
                                 output logic win, output logic [7:0] bx,
                                 output logic [7:0] by, output logic [12:0] map_addr);
    logic [LC_W-1:0] lc;
    logic [12:0]     base;
    lc  = cfg_shadow[CFG_LAYER_CTRL][LC_W-1:0];
    win = lc[LC_WIN_ON] && py >= cfg_shadow[CFG_WINDOW_Y] && px >= cfg_shadow[CFG_WINDOW_X];
    if (win) begin
      bx   = px - cfg_shadow[CFG_WINDOW_X];
      by   = py - cfg_shadow[CFG_WINDOW_Y];
      base = lc[LC_WIN_MAP1] ? MAP1_BASE : MAP0_BASE;
    end else begin
      bx   = px + cfg_shadow[CFG_SCROLL_X];
      by   = py + cfg_shadow[CFG_SCROLL_Y];
      base = lc[LC_BG_MAP1] ? MAP1_BASE : MAP0_BASE;
    end
    map_addr = base + {3'b000, by[7:3], bx[7:3]};
  endfunction

  function automatic logic [12:0] tile_row_addr(input logic [7:0] tile_no,
                                                input logic [7:0] by);
    logic [12:0] base;
    base = {1'b0, tile_no, 4'b0000};
    if (!cfg_shadow[CFG_LAYER_CTRL][LC_UNSIGNED] && !tile_no[7]) begin
      base = base + SIGNED_BASE;
    end
    return base + {9'd0, by[2:0], 1'b0};
  endfunction

  function automatic logic layers_on();
    return cfg_shadow[CFG_LAYER_CTRL][LC_BG_ON] || cfg_shadow[CFG_LAYER_CTRL][LC_WIN_ON];
  endfunction

  function automatic pixel_t render_pixel(input logic [7:0] px, input logic [7:0] py);
    pixel_t      p;
    logic        win;
    logic [7:0]  bx;
    logic [7:0]  by;
    logic [12:0] map_addr;
    logic [12:0] row;
    logic [1:0]  code;
    p = '{shade: 2'd0, gray: 8'hFF, from_window: 1'b0};
    if (layers_on()) begin
      locate(px, py, win, bx, by, map_addr);
      row  = tile_row_addr(vram_model[map_addr], by);
      code = {vram_model[row + 13'd1][~bx[2:0]], vram_model[row][~bx[2:0]]};
      p.shade       = cfg_shadow[CFG_BG_PALETTE][{code, 1'b0} +: 2];
      p.gray        = 8'd255 - 8'd85 * p.shade;
      p.from_window = win;
    end
    return p;
  endfunction

  function automatic void take_request(input pixel_req_t r);
    requests_taken++;
    if (r.act == ACT_WRITE) begin
      vram_model[r.addr] = r.data;
      writes_taken++;
    end else begin
      renders_taken++;
      if (r.px < SCREEN_W) begin
        expected_pixels.push_back(render_pixel(r.px, r.py));
      end
    end
  endfunction

  function automatic void check_pixel();
    pixel_t got;
    pixel_t want;
    got = '{shade: m_axis_tdata[1:0], gray: m_axis_tdata[9:2], from_window: m_axis_tuser};
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("%0t: pixel with none expected: shade %0d gray %0d window %0b",
                 $time, got.shade, got.gray, got.from_window);
      end
    end else begin
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
          $display("%0t: expected shade %0d gray %0d window %0b, got shade %0d gray %0d window %0b",
                   $time, want.shade, want.gray, want.from_window,
                   got.shade, got.gray, got.from_window);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      send_wait     <= 0;
    end else begin : send_side
      int gap;
      gap = send_wait;
      if (s_axis_tvalid && s_axis_tready) begin
        take_request(cur_req);
        gap = draw_gap();
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        send_wait <= 0;
      end else if (gap == 0 && pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cur_req.py, cur_req.px, cur_req.data, cur_req.addr};
        s_axis_tuser  <= cur_req.act;
        send_wait     <= 0;
      end else begin
        s_axis_tvalid <= 1'b0;
        send_wait     <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait     <= 0;
    end else begin : recv_side
      int gap;
      gap = recv_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        check_pixel();
        gap = draw_gap();
      end
      if (out_hold || gap != 0) begin
        m_axis_tready <= 1'b0;
        recv_wait     <= (gap > 0) ? gap - 1 : 0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // The output side stops for a long stretch while requests keep coming.
  initial begin
    wait (requests_taken >= HOLD_AFTER);
    @(posedge clk_i);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    out_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d pixels still expected",
               $time, cycles, expected_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    cfg_shadow[idx] = val;
  endtask

  task automatic apply_setting(input logic [7:0] sx, input logic [7:0] sy,
                               input logic [7:0] wx, input logic [7:0] wy,
                               input logic [7:0] pal, input logic [LC_W-1:0] lc,
                               input logic calm);
    write_reg(CFG_SCROLL_X, sx);
    write_reg(CFG_SCROLL_Y, sy);
    write_reg(CFG_WINDOW_X, wx);
    write_reg(CFG_WINDOW_Y, wy);
    write_reg(CFG_BG_PALETTE, pal);
    write_reg(CFG_LAYER_CTRL, {3'b000, lc});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    steady   <= calm;
    settings_applied++;
  endtask

  task automatic queue_request(input action_e act, input logic [12:0] addr,
                               input logic [7:0] data, input logic [7:0] px,
                               input logic [7:0] py);
    pending_reqs.push_back('{act: act, addr: addr, data: data, px: px, py: py});
    planned_count++;
  endtask

  task automatic plan_write(input logic [12:0] addr, input logic [7:0] data);
    queue_request(ACT_WRITE, addr, data, 8'($urandom), 8'($urandom));
    planned_ram[addr] = data;
    planned_set[addr] = 1'b1;
  endtask

  task automatic touch(input logic [12:0] addr, input logic fresh);
    if (fresh || !planned_set[addr]) begin
      plan_write(addr, 8'($urandom));
    end
  endtask

  // Every byte the render will read is written first; a fresh render rewrites
  // them right before it so that the reads follow closely behind the writes.
  task automatic plan_render(input logic [7:0] px, input logic [7:0] py, input logic fresh);
    logic        win;
    logic [7:0]  bx;
    logic [7:0]  by;
    logic [12:0] map_addr;
    logic [12:0] row;
    if (px < SCREEN_W && layers_on()) begin
      locate(px, py, win, bx, by, map_addr);
      touch(map_addr, fresh);
      row = tile_row_addr(planned_ram[map_addr], by);
      touch(row, fresh);
      touch(row + 13'd1, fresh);
    end
    queue_request(ACT_RENDER, 13'($urandom), 8'($urandom), px, py);
  endtask

  // The state is sampled away from the rising edge so that the driver's
  // updates of that edge are already visible.
  task automatic settle();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int         pick;
    logic [7:0] row_y;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Both layers off: every on-screen pixel is white.
    apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'hE4, '0, 1'b0);
    plan_write(13'd0, 8'h00);
    plan_write(13'h1FFF, 8'hFF);
    plan_render(8'd0, 8'd0, 1'b0);
    plan_render(8'd159, 8'd255, 1'b0);
    plan_render(8'd160, 8'd0, 1'b0);
    plan_render(8'd255, 8'd143, 1'b0);
    settle();

    // Background only with signed tile numbers on both sides of 0x80.
    apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'hE4, LC_BG, 1'b0);
    plan_write(MAP0_BASE, 8'h7F);
    plan_write(MAP0_BASE + 13'd1, 8'h80);
    plan_render(8'd0, 8'd0, 1'b0);
    plan_render(8'd8, 8'd0, 1'b0);
    settle();

    // Both layers, unsigned tiles, window on map 1, scroll that wraps.
    apply_setting(8'd200, 8'd250, 8'd80, 8'd72, 8'h1B,
                  LC_BG | LC_WIN | LC_WMAP1 | LC_UNS, 1'b0);
    plan_render(8'd79, 8'd71, 1'b0);
    plan_render(8'd80, 8'd72, 1'b0);
    plan_render(8'd159, 8'd143, 1'b0);
    plan_render(8'd10, 8'd200, 1'b0);
    settle();

    // Window only: pixels outside it still come from background map 1.
    apply_setting(8'd3, 8'd5, 8'd40, 8'd40, 8'h93, LC_WIN | LC_BGMAP1, 1'b0);
    plan_render(8'd10, 8'd10, 1'b0);
    plan_render(8'd50, 8'd50, 1'b0);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1, 1'b0);
      end else if (ph == 1) begin
        apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, LC_BG | LC_WIN, 1'b1);
      end else begin
        apply_setting(8'($urandom), 8'($urandom), 8'($urandom_range(0, 167)),
                      8'($urandom_range(0, 150)), 8'($urandom), LC_W'($urandom),
                      $urandom_range(0, 3) == 0);
      end
      planned_count = 0;
      while (planned_count < PHASE_REQS) begin
        pick  = $urandom_range(0, 99);
        row_y = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 143));
        if (pick < 8) begin
          plan_write(13'($urandom), 8'($urandom));
        end else if (pick < 16) begin
          plan_render(8'($urandom_range(SCREEN_W, 255)), row_y, 1'b0);
        end else begin
          plan_render(8'($urandom_range(0, SCREEN_W - 1)), row_y, pick < 40);
        end
      end
      settle();
    end

    $display("%0d requests taken: %0d pixel renders, %0d video RAM writes, %0d pixels checked",
             requests_taken, renders_taken, writes_taken, pixels_checked);
    $display("%0d register settings from all zeros to all ones, with a %0d-cycle output hold",
             settings_applied, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
